// File: rtl/core/tune_beacon_epoch_gate_unit_assert.svh
// Assertion macros used by the beacon gate port checker
`ifndef TUNE_BEACON_EPOCH_GATE_UNIT_ASSERT_SVH
`define TUNE_BEACON_EPOCH_GATE_UNIT_ASSERT_SVH

// clocked implication check, masked while in reset
`define TBEG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// a result held back by the consumer keeps the named field
`define TBEG_ASSERT_HOLD(lbl, sig, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) \
		(out_valid && !out_ready) |=> $stable(sig)) else $error(msg);

`endif

// File: rtl/core/tbeg_pkg.sv
// Types and constants of the tuning beacon epoch gate
package tbeg_pkg;

	localparam int unsigned NUM_SETTINGS = 5;
	localparam int unsigned SLOT_W = 3;

	localparam logic [7:0] BEACON_TYPE   = 8'hAC;
	localparam logic [6:0] BEACON_VER    = 7'd1;
	localparam logic [7:0] MIN_LEN       = 8'd4;
	localparam logic [7:0] EPOCH_LEN     = 8'd5;
	localparam logic [7:0] ID_FIRST      = 8'd1;
	localparam logic [7:0] ID_LAST       = 8'd5;

	localparam logic [7:0] BUF_MIN       = 8'd4;
	localparam logic [7:0] BUF_MAX       = 8'd60;
	localparam logic [7:0] LOCK_MIN      = 8'd5;
	localparam logic [7:0] LOCK_MAX      = 8'd50;
	localparam logic [7:0] GAP_MIN       = 8'd4;
	localparam logic [7:0] GAP_MAX       = 8'd64;
	localparam logic [7:0] VOL_MIN       = 8'd10;
	localparam logic [7:0] VOL_MAX       = 8'd100;

	typedef enum logic [SLOT_W-1:0] {
		KIND_BUFFER    = 3'd0,
		KIND_SELECTION = 3'd1,
		KIND_LOCK      = 3'd2,
		KIND_RESYNC    = 3'd3,
		KIND_VOLUME    = 3'd4
	} setting_kind_t;

	typedef struct packed {
		logic       seen;
		logic [7:0] epoch;
	} epoch_rd_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] slot;
		logic [7:0]        epoch;
	} epoch_wr_t;

	typedef struct packed {
		logic       applied;
		logic [2:0] kind;
		logic [8:0] value;
	} beacon_res_t;

endpackage

// File: rtl/core/tbeg_epoch_store.sv
// Per-setting last epoch and seen flag, cleared at reset
module tbeg_epoch_store import tbeg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [SLOT_W-1:0] rd_slot,
	output epoch_rd_t         rd,
	input  epoch_wr_t         wr
);

	logic [7:0]            epoch_q [NUM_SETTINGS];
	logic [NUM_SETTINGS-1:0] seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			for (int i = 0; i < NUM_SETTINGS; i++) begin
				epoch_q[i] <= '0;
			end
		end else if (wr.en && (wr.slot < SLOT_W'(NUM_SETTINGS))) begin
			seen_q[wr.slot] <= 1'b1;
			epoch_q[wr.slot] <= wr.epoch;
		end
	end

	always_comb begin
		rd = '0;
		if (rd_slot < SLOT_W'(NUM_SETTINGS)) begin
			rd.seen = seen_q[rd_slot];
			rd.epoch = epoch_q[rd_slot];
		end
	end

endmodule

// File: rtl/core/tbeg_check.sv
// Header, epoch and range checks for one registered beacon
module tbeg_check import tbeg_pkg::*; (
	input  logic              take,
	input  logic [7:0]        frame_length,
	input  logic [7:0]        packet_type,
	input  logic [7:0]        version_byte,
	input  logic [7:0]        setting_id,
	input  logic [7:0]        setting_byte,
	input  logic [7:0]        epoch_byte,
	output logic [SLOT_W-1:0] rd_slot,
	input  epoch_rd_t         rd,
	output epoch_wr_t         wr,
	output beacon_res_t       res
);

	logic        hdr_ok;
	logic        id_ok;
	logic        carries;
	logic        older;
	logic        range_ok;
	logic [7:0]  diff;
	logic [8:0]  val;
	logic [8:0]  lock_ms;
	logic        pass;

	assign hdr_ok  = (frame_length >= MIN_LEN) && (packet_type == BEACON_TYPE)
		&& (version_byte[6:0] == BEACON_VER);
	assign id_ok   = setting_id inside {[ID_FIRST:ID_LAST]};
	assign rd_slot = SLOT_W'(setting_id - ID_FIRST);
	assign carries = frame_length >= EPOCH_LEN;

	// wrap-safe: negative 8-bit difference means strictly older
	assign diff  = epoch_byte - rd.epoch;
	assign older = carries && rd.seen && diff[7];

	// only used in range (5..50), so nine bits hold the product
	assign lock_ms = {1'b0, setting_byte} * 9'd10;

	always_comb begin
		range_ok = 1'b0;
		val = '0;
		case (rd_slot)
			KIND_BUFFER: begin
				range_ok = (setting_byte == 8'd0) || (setting_byte inside {[BUF_MIN:BUF_MAX]});
				val = {1'b0, setting_byte};
			end
			KIND_SELECTION: begin
				range_ok = 1'b1;
				val = {8'd0, |setting_byte};
			end
			KIND_LOCK: begin
				range_ok = setting_byte inside {[LOCK_MIN:LOCK_MAX]};
				val = lock_ms;
			end
			KIND_RESYNC: begin
				range_ok = setting_byte inside {[GAP_MIN:GAP_MAX]};
				val = {1'b0, setting_byte};
			end
			KIND_VOLUME: begin
				range_ok = setting_byte inside {[VOL_MIN:VOL_MAX]};
				val = {1'b0, setting_byte};
			end
			default: begin
				range_ok = 1'b0;
				val = '0;
			end
		endcase
	end

	assign pass = hdr_ok && id_ok && !older && range_ok;

	always_comb begin
		res = '0;
		if (pass) begin
			res.applied = 1'b1;
			res.kind = rd_slot;
			res.value = val;
		end
	end

	assign wr.en    = take && pass && carries;
	assign wr.slot  = rd_slot;
	assign wr.epoch = epoch_byte;

endmodule

// File: rtl/core/tune_beacon_epoch_gate_unit.sv
// Top level of the tuning beacon epoch gate
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | frame_length .. epoch_byte
//  out     | output    | out_valid / out_ready| applied, setting_kind, applied_value
// One beacon per cycle while the out channel is not stalled; input register, then result register.
// The check and the epoch store update run between the two registers, so the
// next beacon sees the updated epoch in the following cycle.
// Reset clears the epoch store and both valid flags.
// A stalled result holds; input is still taken while the result register drains.
module tune_beacon_epoch_gate_unit import tbeg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] frame_length,
	input  logic [7:0] packet_type,
	input  logic [7:0] version_byte,
	input  logic [7:0] setting_id,
	input  logic [7:0] setting_byte,
	input  logic [7:0] epoch_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       applied,
	output logic [2:0] setting_kind,
	output logic [8:0] applied_value
);

	logic        valid_s1;
	logic [7:0]  len_s1;
	logic [7:0]  type_s1;
	logic [7:0]  ver_s1;
	logic [7:0]  id_s1;
	logic [7:0]  raw_s1;
	logic [7:0]  ep_s1;
	logic        valid_s2;
	beacon_res_t res_s2;

	logic              s2_en;
	logic              s1_adv;
	logic [SLOT_W-1:0] rd_slot;
	epoch_rd_t         rd;
	epoch_wr_t         wr;
	beacon_res_t       res;

	assign s2_en    = !valid_s2 || out_ready;
	assign s1_adv   = valid_s1 && s2_en;
	assign in_ready = !valid_s1 || s2_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			len_s1  <= frame_length;
			type_s1 <= packet_type;
			ver_s1  <= version_byte;
			id_s1   <= setting_id;
			raw_s1  <= setting_byte;
			ep_s1   <= epoch_byte;
		end
	end

	tbeg_check u_check (
		.take         (s1_adv),
		.frame_length (len_s1),
		.packet_type  (type_s1),
		.version_byte (ver_s1),
		.setting_id   (id_s1),
		.setting_byte (raw_s1),
		.epoch_byte   (ep_s1),
		.rd_slot      (rd_slot),
		.rd           (rd),
		.wr           (wr),
		.res          (res)
	);

	tbeg_epoch_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_slot (rd_slot),
		.rd      (rd),
		.wr      (wr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			res_s2 <= res;
		end
	end

	assign out_valid     = valid_s2;
	assign applied       = res_s2.applied;
	assign setting_kind  = res_s2.kind;
	assign applied_value = res_s2.value;

endmodule

// File: rtl/core/tbeg_checker.sv
// Port-level checks for the tuning beacon epoch gate, bound to the top level
`include "tune_beacon_epoch_gate_unit_assert.svh"

module tbeg_checker import tbeg_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       applied,
	input logic [2:0] setting_kind,
	input logic [8:0] applied_value
);

	// an empty result register must never throttle the input
	`TBEG_ASSERT(a_ready_when_drained, !out_valid |=> in_ready || out_valid, "input stalled with no result pending")

	// rejected beacons carry an all-zero payload
	`TBEG_ASSERT(a_reject_zero, (out_valid && !applied) |-> (setting_kind == 3'd0 && applied_value == 9'd0), "rejected result not zeroed")

	// selection is a flag
	`TBEG_ASSERT(a_selection_flag, (out_valid && applied && setting_kind == KIND_SELECTION) |-> (applied_value <= 9'd1), "selection value above one")

	`TBEG_ASSERT_HOLD(a_value_hold, applied_value, "result value changed while stalled")

endmodule

bind tune_beacon_epoch_gate_unit tbeg_checker u_tbeg_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.applied       (applied),
	.setting_kind  (setting_kind),
	.applied_value (applied_value)
);

// File: verif/tune_beacon_epoch_gate_unit_checker.sv
// Checker for the tuning beacon epoch gate: predicts each result and compares the out channel
module tune_beacon_epoch_gate_unit_checker import tbeg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] frame_length,
	input  logic [7:0] packet_type,
	input  logic [7:0] version_byte,
	input  logic [7:0] setting_id,
	input  logic [7:0] setting_byte,
	input  logic [7:0] epoch_byte,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic       applied,
	input  logic [2:0] setting_kind,
	input  logic [8:0] applied_value,
	output int         fail_count,
	output int         pending,
	output int         result_count,
	output int         applied_count
);

	localparam logic [8:0] LOCK_SCALE = 9'd10;

	logic [7:0]  latched_epoch [NUM_SETTINGS];
	logic        epoch_latched [NUM_SETTINGS];
	beacon_res_t expected_results [$];
	beacon_res_t want;

	// Decide one beacon and update the per-setting epoch store
	function automatic beacon_res_t gate_beacon(input logic [7:0] len, input logic [7:0] typ,
			input logic [7:0] ver, input logic [7:0] id, input logic [7:0] raw,
			input logic [7:0] ep);
		beacon_res_t   res;
		setting_kind_t kind;
		logic [7:0]    slot;
		logic [7:0]    age;
		logic          in_range;
		logic [8:0]    value;
		res = '0;
		if (len < MIN_LEN || typ != BEACON_TYPE || ver[6:0] != BEACON_VER)
			return res;
		if (id < ID_FIRST || id > ID_LAST)
			return res;
		slot = id - ID_FIRST;
		kind = setting_kind_t'(slot[2:0]);
		// wrap-safe age: bit 7 of the difference marks a strictly older epoch
		if (len >= EPOCH_LEN && epoch_latched[kind]) begin
			age = ep - latched_epoch[kind];
			if (age[7])
				return res;
		end
		value = {1'b0, raw};
		case (kind)
			KIND_BUFFER: begin
				in_range = (raw == 8'd0) || (raw >= BUF_MIN && raw <= BUF_MAX);
			end
			KIND_SELECTION: begin
				in_range = 1'b1;
				value = {8'd0, raw != 8'd0};
			end
			KIND_LOCK: begin
				in_range = raw >= LOCK_MIN && raw <= LOCK_MAX;
				value = {1'b0, raw} * LOCK_SCALE;
			end
			KIND_RESYNC: begin
				in_range = raw >= GAP_MIN && raw <= GAP_MAX;
			end
			default: begin
				in_range = raw >= VOL_MIN && raw <= VOL_MAX;
			end
		endcase
		if (!in_range)
			return res;
		if (len >= EPOCH_LEN) begin
			latched_epoch[kind] = ep;
			epoch_latched[kind] = 1'b1;
		end
		res.applied = 1'b1;
		res.kind = kind;
		res.value = value;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SETTINGS; i++) begin
				latched_epoch[i] = 8'd0;
				epoch_latched[i] = 1'b0;
			end
			expected_results.delete();
			fail_count = 0;
			result_count = 0;
			applied_count = 0;
			pending = 0;
		end else begin
			// a result never belongs to the transaction taken at the same edge
			if (out_valid && out_ready) begin
				result_count++;
				if (applied === 1'b1)
					applied_count++;
				if (expected_results.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result: applied %b kind %0d value %0d",
						$time, applied, setting_kind, applied_value);
				end else begin
					want = expected_results.pop_front();
					if (applied !== want.applied) begin
						fail_count++;
						$display("%0t: applied mismatch: expected %b, actual %b",
							$time, want.applied, applied);
					end
					if (setting_kind !== want.kind) begin
						fail_count++;
						$display("%0t: setting_kind mismatch: expected %0d, actual %0d",
							$time, want.kind, setting_kind);
					end
					if (applied_value !== want.value) begin
						fail_count++;
						$display("%0t: applied_value mismatch: expected %0d, actual %0d",
							$time, want.value, applied_value);
					end
				end
			end
			if (in_valid && in_ready)
				expected_results.push_back(gate_beacon(frame_length, packet_type,
					version_byte, setting_id, setting_byte, epoch_byte));
			pending = expected_results.size();
		end
	end

endmodule

// File: verif/tune_beacon_epoch_gate_unit_tb.sv
// Testbench top for the tuning beacon epoch gate: clock, reset, beacon stimulus and verdict
module tune_beacon_epoch_gate_unit_tb;
	import tbeg_pkg::*;

	localparam logic [7:0] SET_BUFFER    = 8'd1;
	localparam logic [7:0] SET_SELECTION = 8'd2;
	localparam logic [7:0] SET_LOCK      = 8'd3;
	localparam logic [7:0] SET_RESYNC    = 8'd4;
	localparam logic [7:0] SET_VOLUME    = 8'd5;
	localparam logic [7:0] VER_PLAIN     = 8'h01;
	localparam logic [7:0] VER_RELAYED   = 8'h81;
	localparam int         RANDOM_ITEMS  = 800;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] frame_length = 8'd0;
	logic [7:0] packet_type = 8'd0;
	logic [7:0] version_byte = 8'd0;
	logic [7:0] setting_id = 8'd0;
	logic [7:0] setting_byte = 8'd0;
	logic [7:0] epoch_byte = 8'd0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       applied;
	logic [2:0] setting_kind;
	logic [8:0] applied_value;

	int   fail_count;
	int   pending;
	int   result_count;
	int   applied_count;
	int   sent_count = 0;
	logic in_fire = 1'b0;
	logic stall_on = 1'b1;
	logic idle_on = 1'b1;

	tune_beacon_epoch_gate_unit dut (.*);

	tune_beacon_epoch_gate_unit_checker checker_i (.*);

	initial begin
		forever #2 clk = ~clk;
	end

	// registered view of the input handshake, stable for the sender at the falling edge
	always @(posedge clk)
		in_fire <= in_valid && in_ready;

	always @(negedge clk)
		out_ready <= !stall_on || ($urandom_range(99) >= 6);

	// called at a falling edge; returns at the falling edge after the transaction
	task automatic send_beacon(input logic [7:0] len, input logic [7:0] typ,
			input logic [7:0] ver, input logic [7:0] id, input logic [7:0] raw,
			input logic [7:0] ep);
		int gap;
		if (idle_on && $urandom_range(99) < 6) begin
			gap = $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		frame_length <= len;
		packet_type <= typ;
		version_byte <= ver;
		setting_id <= id;
		setting_byte <= raw;
		epoch_byte <= ep;
		do @(negedge clk); while (!in_fire);
		sent_count++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	initial begin
		logic [7:0] len, typ, ver, id, raw, ep, flip;
		logic [7:0] tx_epoch [NUM_SETTINGS];
		int         slot, pick, directed_count;

		for (int i = 0; i < NUM_SETTINGS; i++)
			tx_epoch[i] = 8'd0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// framing rejects, relayed flag, unknown setting codes
		send_beacon(8'd3, BEACON_TYPE, VER_PLAIN, SET_BUFFER, 8'd10, 8'd0);
		send_beacon(8'd4, 8'h00, VER_PLAIN, SET_BUFFER, 8'd10, 8'd0);
		send_beacon(8'd4, BEACON_TYPE, 8'h00, SET_BUFFER, 8'd10, 8'd0);
		send_beacon(8'd4, BEACON_TYPE, 8'hFF, SET_BUFFER, 8'd10, 8'd0);
		send_beacon(8'd4, BEACON_TYPE, VER_RELAYED, SET_BUFFER, 8'd0, 8'hFF);
		send_beacon(8'd4, BEACON_TYPE, VER_PLAIN, 8'd0, 8'd10, 8'd0);
		send_beacon(8'd4, BEACON_TYPE, VER_PLAIN, 8'd6, 8'd10, 8'd0);
		send_beacon(8'd250, BEACON_TYPE, VER_PLAIN, 8'd255, 8'd255, 8'd255);
		// range edges, no epoch carried
		send_beacon(8'd4, BEACON_TYPE, VER_PLAIN, SET_BUFFER, 8'd3, 8'hFF);
		send_beacon(8'd4, BEACON_TYPE, VER_PLAIN, SET_BUFFER, 8'd60, 8'hFF);
		send_beacon(8'd4, BEACON_TYPE, VER_PLAIN, SET_BUFFER, 8'd61, 8'hFF);
		send_beacon(8'd4, BEACON_TYPE, VER_PLAIN, SET_SELECTION, 8'd0, 8'hFF);
		send_beacon(8'd4, BEACON_TYPE, VER_PLAIN, SET_SELECTION, 8'd255, 8'hFF);
		send_beacon(8'd4, BEACON_TYPE, VER_PLAIN, SET_LOCK, 8'd5, 8'hFF);
		send_beacon(8'd4, BEACON_TYPE, VER_PLAIN, SET_LOCK, 8'd50, 8'hFF);
		send_beacon(8'd4, BEACON_TYPE, VER_PLAIN, SET_LOCK, 8'd51, 8'hFF);
		send_beacon(8'd4, BEACON_TYPE, VER_PLAIN, SET_RESYNC, 8'd65, 8'hFF);
		send_beacon(8'd4, BEACON_TYPE, VER_PLAIN, SET_VOLUME, 8'd9, 8'hFF);
		send_beacon(8'd4, BEACON_TYPE, VER_PLAIN, SET_VOLUME, 8'd100, 8'hFF);
		// epoch sequence on resync gap: first, half-way back, newest, repeat, older,
		// bad value must not latch, then wrap past 0xFF
		send_beacon(8'd5, BEACON_TYPE, VER_PLAIN, SET_RESYNC, 8'd10, 8'h00);
		send_beacon(8'd5, BEACON_TYPE, VER_PLAIN, SET_RESYNC, 8'd10, 8'h80);
		send_beacon(8'd5, BEACON_TYPE, VER_PLAIN, SET_RESYNC, 8'd10, 8'h7F);
		send_beacon(8'd5, BEACON_TYPE, VER_PLAIN, SET_RESYNC, 8'd64, 8'h7F);
		send_beacon(8'd5, BEACON_TYPE, VER_PLAIN, SET_RESYNC, 8'd10, 8'h7E);
		send_beacon(8'd5, BEACON_TYPE, VER_PLAIN, SET_RESYNC, 8'd65, 8'hF0);
		send_beacon(8'd5, BEACON_TYPE, VER_PLAIN, SET_RESYNC, 8'd4, 8'hFE);
		send_beacon(8'd5, BEACON_TYPE, VER_PLAIN, SET_RESYNC, 8'd10, 8'h10);
		directed_count = sent_count;
		drain_results();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			idle_on = !(i >= 300 && i < 480);
			stall_on <= !(i >= 300 && i < 480);
			if (i == 600)
				drain_results();
			// well-formed beacon with a roughly advancing epoch per setting
			slot = $urandom_range(NUM_SETTINGS - 1);
			pick = $urandom_range(9);
			if (pick < 6)
				tx_epoch[slot] += 8'($urandom_range(3));
			else if (pick < 8)
				tx_epoch[slot] -= 8'($urandom_range(1, 20));
			else if (pick == 8)
				tx_epoch[slot] = 8'($urandom_range(255));
			if ($urandom_range(3) == 0)
				len = MIN_LEN;
			else if ($urandom_range(7) == 0)
				len = 8'($urandom_range(5, 250));
			else
				len = 8'($urandom_range(5, 16));
			typ = BEACON_TYPE;
			ver = VER_PLAIN;
			ver[7] = 1'($urandom_range(1));
			id = ID_FIRST + 8'(slot);
			raw = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(110));
			ep = tx_epoch[slot];
			pick = $urandom_range(99);
			if (pick < 12) begin
				// pure noise
				len = 8'($urandom_range(250));
				typ = 8'($urandom_range(255));
				ver = 8'($urandom_range(255));
				id = 8'($urandom_range(255));
				raw = 8'($urandom_range(255));
				ep = 8'($urandom_range(255));
			end else if (pick < 22) begin
				// one framing field broken
				case ($urandom_range(3))
					0: len = 8'($urandom_range(3));
					1: begin
						flip = 8'($urandom_range(1, 255));
						typ = BEACON_TYPE ^ flip;
					end
					2: ver[6:0] = 7'($urandom_range(127));
					default: id = $urandom_range(1) ? 8'd0 : 8'($urandom_range(6, 255));
				endcase
			end
			send_beacon(len, typ, ver, id, raw, ep);
		end

		in_valid <= 1'b0;
		stall_on <= 1'b1;
		do @(negedge clk); while (pending != 0);
		repeat (8) @(negedge clk);

		$display("Covered %0d beacons (%0d directed) with idle and stall gaps, one drain pause.",
			sent_count, directed_count);
		$display("Checked %0d results: %0d applied, %0d rejected.",
			result_count, applied_count, result_count - applied_count);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#400000;
		$display("Timeout with %0d results outstanding", pending);
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/tbeg_pkg.sv
rtl/core/tbeg_epoch_store.sv
rtl/core/tbeg_check.sv
rtl/core/tune_beacon_epoch_gate_unit.sv
rtl/core/tbeg_checker.sv
verif/tune_beacon_epoch_gate_unit_checker.sv
verif/tune_beacon_epoch_gate_unit_tb.sv
